// ----- rtl/core/i2c_master_byte_sequencer_macros.svh -----
// Assertion macros for the I2C master byte sequencer checker.
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/i2cms_pkg.sv -----
package i2cms_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    localparam logic [1:0] LAST_SEG      = 2'd2;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] DELAY_RESET   = 8'd1;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } t_out_item;

endpackage

// ----- rtl/core/i2c_master_byte_sequencer.sv -----
// A request waits in the input register; its result is then held in the result register.
// Throughput: one request per cycle unless results stall; one state step per request.
// One input register and one result register: while a result is stalled, one more
// request is taken into the input register, then o_in_ready drops.
// Reset (i_rst_n low, synchronous): both stages empty, sequencer idle,
// SCL/SDA released high, delay_ticks back to 1, received byte and ack flag cleared.
module i2c_master_byte_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: delay_ticks
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_received
);
    import i2cms_pkg::*;

    t_in_item  in_item;
    t_in_item  stg_item;
    t_out_item step_item;
    t_out_item out_item;
    logic      stg_valid;
    logic      out_ready;
    logic      step;

    assign in_item.action   = i_action;
    assign in_item.tx_byte  = i_tx_byte;
    assign in_item.send_ack = i_send_ack;
    assign in_item.sda_in   = i_sda_in;

    // A staged tick advances the bus state only when its result has room.
    assign step = stg_valid && out_ready;

    i2cms_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stg_valid),
        .i_take  (step),
        .o_item  (stg_item)
    );

    // Sequencer: start/stop/byte segments, delay counting, SDA sampling.
    i2cms_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (stg_item),
        .o_item      (step_item)
    );

    i2cms_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid),
        .o_ready (out_ready),
        .i_item  (step_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (out_item)
    );

    assign o_scl_out      = out_item.scl_out;
    assign o_sda_out      = out_item.sda_out;
    assign o_busy_res     = out_item.busy_res;
    assign o_done_res     = out_item.done_res;
    assign o_rx_byte      = out_item.rx_byte;
    assign o_ack_received = out_item.ack_received;

endmodule

// ----- rtl/core/i2cms_in_stage.sv -----
module i2cms_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cms_pkg::t_in_item i_item,
    output logic                o_valid,
    input  logic                i_take,
    output i2cms_pkg::t_in_item o_item
);
    import i2cms_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/core/i2cms_core.sv -----
module i2cms_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_step,
    input  i2cms_pkg::t_in_item  i_item,
    output i2cms_pkg::t_out_item o_item
);
    import i2cms_pkg::*;

    logic [7:0] r_delay;
    t_op        r_op,    n_op;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_bit,   n_bit;
    logic [7:0] r_dly,   n_dly;
    logic [7:0] r_shift, n_shift;
    logic       r_ack_send, n_ack_send;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic [7:0] r_rx,    n_rx;
    logic       r_ack_flag, n_ack_flag;

    logic       start_cmd;
    t_op        c_op;
    logic [1:0] c_phase;
    logic [1:0] ps;
    logic [7:0] units;
    logic       seg_end;
    logic       busy;
    logic       done;
    logic       bit_val;
    logic [7:0] shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    always_comb begin
        start_cmd = (r_op == OP_IDLE) && (i_item.action >= OP_START)
                    && (i_item.action <= OP_READ);
        c_op      = start_cmd ? t_op'(i_item.action) : r_op;
        c_phase   = start_cmd ? 2'd0 : r_phase;
        ps        = (c_phase > LAST_SEG) ? LAST_SEG : c_phase;
        units     = (r_delay == 8'd0) ? 8'd1 : r_delay;

        n_op       = c_op;
        n_phase    = c_phase;
        n_bit      = start_cmd ? 4'd0 : r_bit;
        n_dly      = start_cmd ? 8'd0 : r_dly;
        n_shift    = r_shift;
        n_ack_send = r_ack_send;
        if (start_cmd) begin
            n_shift    = (i_item.action == OP_WRITE) ? i_item.tx_byte : 8'd0;
            n_ack_send = i_item.send_ack;
        end
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rx       = r_rx;
        n_ack_flag = r_ack_flag;
        busy       = 1'b0;
        done       = 1'b0;
        seg_end    = ({1'b0, n_dly} + 9'd1) >= {1'b0, units};
        shifted    = {n_shift[6:0], (c_op == OP_READ) ? i_item.sda_in : 1'b0};

        // bit value on SDA for a byte command
        if (n_bit < BITS_PER_BYTE) begin
            bit_val = (c_op == OP_WRITE) ? n_shift[7] : 1'b1;
        end else begin
            bit_val = (c_op == OP_WRITE) ? 1'b1 : !n_ack_send;
        end

        if (c_op != OP_IDLE) begin
            busy = 1'b1;
            // drive the current segment
            if (c_op == OP_START) begin
                n_scl = (ps != LAST_SEG);
                n_sda = (ps == 2'd0);
            end else if (c_op == OP_STOP) begin
                n_scl = (ps != 2'd0);
                n_sda = (ps == LAST_SEG);
            end else if (n_bit > BITS_PER_BYTE) begin
                n_scl = 1'b0;
            end else begin
                n_scl = (c_phase != 2'd0);
                n_sda = bit_val;
            end

            if (seg_end) begin
                n_dly = 8'd0;
                if (c_op == OP_START || c_op == OP_STOP) begin
                    if (c_phase >= LAST_SEG) begin
                        done = 1'b1;
                    end else begin
                        n_phase = c_phase + 2'd1;
                    end
                end else if (n_bit > BITS_PER_BYTE) begin
                    done = 1'b1;
                end else if (c_phase == 2'd0) begin
                    n_phase = 2'd1;
                end else begin
                    // end of SCL-high: sample SDA
                    if (n_bit < BITS_PER_BYTE) begin
                        n_shift = shifted;
                        if (c_op == OP_READ && n_bit == BITS_PER_BYTE - 4'd1) begin
                            n_rx = shifted;
                        end
                    end else if (c_op == OP_WRITE) begin
                        n_ack_flag = !i_item.sda_in;
                    end
                    n_phase = 2'd0;
                    n_bit   = n_bit + 4'd1;
                end
                if (done) begin
                    n_op    = OP_IDLE;
                    n_phase = 2'd0;
                    n_bit   = 4'd0;
                    n_dly   = 8'd0;
                end
            end else begin
                n_dly = n_dly + 8'd1;
            end
        end

        o_item.scl_out      = n_scl;
        o_item.sda_out      = n_sda;
        o_item.busy_res     = busy;
        o_item.done_res     = done;
        o_item.rx_byte      = n_rx;
        o_item.ack_received = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op       <= OP_IDLE;
            r_phase    <= 2'd0;
            r_bit      <= 4'd0;
            r_dly      <= 8'd0;
            r_shift    <= 8'd0;
            r_ack_send <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_rx       <= 8'd0;
            r_ack_flag <= 1'b0;
        end else if (i_step) begin
            r_op       <= n_op;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_dly      <= n_dly;
            r_shift    <= n_shift;
            r_ack_send <= n_ack_send;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_rx       <= n_rx;
            r_ack_flag <= n_ack_flag;
        end
    end

endmodule

// ----- rtl/core/i2cms_out_stage.sv -----
module i2cms_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  i2cms_pkg::t_out_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cms_pkg::t_out_item o_item
);
    import i2cms_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/core/i2cms_checker.sv -----
`include "i2c_master_byte_sequencer_macros.svh"

module i2cms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_ack_received
);

    `I2CMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result dropped while stalled")
    `I2CMS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_scl_out) && $stable(o_sda_out) && $stable(o_rx_byte)
        && $stable(o_ack_received), "stalled result changed")
    `I2CMS_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_out_valid && o_done_res,
        o_busy_res, "done without busy")
    `I2CMS_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !o_out_valid,
        o_in_ready, "request refused with empty result stage")

endmodule

bind i2c_master_byte_sequencer i2cms_checker u_chk (.*);

// ----- verif/i2cms_scoreboard_pkg.sv -----
`timescale 1ns / 1ps

package i2cms_scoreboard_pkg;
    import i2cms_pkg::*;

    class bus_level_scoreboard;
        // mirror of the sequencer
        logic [7:0] delay_ticks;
        t_op        op;
        logic [2:0] seg;
        logic [3:0] nbit;
        logic [7:0] dcnt;
        logic [7:0] shreg;
        logic       ack_tx;
        logic       scl;
        logic       sda;
        logic [7:0] rx_latch;
        logic       ack_seen;

        t_out_item  expected_levels[$];
        int         mismatch_count;
        int         results_seen;

        function new();
            delay_ticks    = DELAY_RESET;
            op             = OP_IDLE;
            seg            = '0;
            nbit           = '0;
            dcnt           = '0;
            shreg          = '0;
            ack_tx         = 1'b0;
            scl            = 1'b1;
            sda            = 1'b1;
            rx_latch       = '0;
            ack_seen       = 1'b0;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function void report_mismatch(string what);
            $display("ERROR result %0d: %s", results_seen, what);
            mismatch_count++;
        endfunction

        // Advance one tick for an accepted request and queue the line levels it gives.
        function void predict_levels(t_in_item req);
            logic [7:0] units;
            logic       busy;
            logic       done;
            logic       fin;
            t_out_item  want;

            units = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
            busy  = 1'b0;
            done  = 1'b0;
            fin   = 1'b0;

            if (op == OP_IDLE && req.action >= OP_START && req.action <= OP_READ) begin
                op     = t_op'(req.action);
                seg    = '0;
                nbit   = '0;
                dcnt   = '0;
                shreg  = (req.action == OP_WRITE) ? req.tx_byte : 8'd0;
                ack_tx = req.send_ack;
            end

            if (op != OP_IDLE) begin
                busy = 1'b1;
                // levels of the current segment
                if (op == OP_START) begin
                    scl = (seg < LAST_SEG);
                    sda = (seg == 3'd0);
                end else if (op == OP_STOP) begin
                    scl = (seg != 3'd0);
                    sda = (seg >= LAST_SEG);
                end else if (nbit > BITS_PER_BYTE) begin
                    scl = 1'b0;
                end else begin
                    scl = (seg != 3'd0);
                    if (nbit < BITS_PER_BYTE) begin
                        sda = (op == OP_WRITE) ? shreg[7] : 1'b1;
                    end else begin
                        sda = (op == OP_WRITE) ? 1'b1 : !ack_tx;
                    end
                end

                if (({1'b0, dcnt} + 9'd1) >= {1'b0, units}) begin
                    dcnt = '0;
                    // segment end: sample on the close of SCL high, step on
                    if (op == OP_START || op == OP_STOP) begin
                        if (seg >= LAST_SEG) begin
                            fin = 1'b1;
                        end else begin
                            seg = seg + 3'd1;
                        end
                    end else if (nbit > BITS_PER_BYTE) begin
                        fin = 1'b1;
                    end else if (seg == 3'd0) begin
                        seg = 3'd1;
                    end else begin
                        if (op == OP_WRITE) begin
                            if (nbit < BITS_PER_BYTE) begin
                                shreg = shreg << 1;
                            end else begin
                                ack_seen = !req.sda_in;
                            end
                        end else if (nbit < BITS_PER_BYTE) begin
                            shreg = {shreg[6:0], req.sda_in};
                            if (nbit == BITS_PER_BYTE - 4'd1) begin
                                rx_latch = shreg;
                            end
                        end
                        seg  = '0;
                        nbit = nbit + 4'd1;
                    end
                    if (fin) begin
                        op   = OP_IDLE;
                        seg  = '0;
                        nbit = '0;
                        dcnt = '0;
                        done = 1'b1;
                    end
                end else begin
                    dcnt = dcnt + 8'd1;
                end
            end

            want.scl_out      = scl;
            want.sda_out      = sda;
            want.busy_res     = busy;
            want.done_res     = done;
            want.rx_byte      = rx_latch;
            want.ack_received = ack_seen;
            expected_levels.push_back(want);
        endfunction

        function void check_levels(t_out_item got);
            t_out_item want;

            results_seen++;
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("no request pending, got %h", got));
                return;
            end
            want = expected_levels.pop_front();
            if (got.scl_out !== want.scl_out) begin
                report_mismatch($sformatf("scl %b exp %b", got.scl_out, want.scl_out));
            end
            if (got.sda_out !== want.sda_out) begin
                report_mismatch($sformatf("sda %b exp %b", got.sda_out, want.sda_out));
            end
            if (got.busy_res !== want.busy_res) begin
                report_mismatch($sformatf("busy %b exp %b", got.busy_res, want.busy_res));
            end
            if (got.done_res !== want.done_res) begin
                report_mismatch($sformatf("done %b exp %b", got.done_res, want.done_res));
            end
            if (got.rx_byte !== want.rx_byte) begin
                report_mismatch($sformatf("rx_byte %h exp %h", got.rx_byte, want.rx_byte));
            end
            if (got.ack_received !== want.ack_received) begin
                report_mismatch($sformatf("ack %b exp %b", got.ack_received,
                                          want.ack_received));
            end
        endfunction
    endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import i2cms_pkg::*;
    import i2cms_scoreboard_pkg::*;

    // generous: the slowest run (random long gaps and long stalls) stays far below
    localparam int CYCLE_LIMIT = 600000;

    // SDA pattern fed while a command runs
    localparam int SDA_LOW  = 0;
    localparam int SDA_ONE  = 1;
    localparam int SDA_RAND = 2;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_action;
    logic [7:0] i_tx_byte;
    logic       i_send_ack;
    logic       i_sda_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_scl_out;
    logic       o_sda_out;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_ack_received;

    bus_level_scoreboard sb;
    t_in_item            txn_plan[$];   // queued commands of the current bus transaction
    int                  items_sent;
    int                  cycle_count;
    int                  ready_hold;    // cycles of result stall still to go
    bit                  send_idle;     // request side inserts gaps
    bit                  stall_on;      // result side inserts stalls

    i2c_master_byte_sequencer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_received (o_ack_received)
    );

    always #4 i_clk = ~i_clk;

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 25)
                                                        : $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result monitor. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_levels({o_scl_out, o_sda_out, o_busy_res, o_done_res,
                             o_rx_byte, o_ack_received});
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("i2c_master_byte_sequencer: mismatch");
            $finish;
        end
    end

    // One request: optional gap, then hold valid until the sequencer takes it.
    // Returns on the accepting edge with valid still high.
    task automatic send_req(input logic [2:0] act, input logic [7:0] tx,
                            input logic ack, input logic sda);
        int gap;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_tx_byte  <= tx;
        i_send_ack <= ack;
        i_sda_in   <= sda;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.predict_levels({act, tx, ack, sda});
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge i_clk);
    endtask

    // Only called once settled, so no request is in flight.
    task automatic write_delay(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.delay_ticks = value;
    endtask

    // Issue one command and tick until it completes. With noise on, some ticks
    // carry commands or unused action codes, which a busy sequencer treats as ticks.
    task automatic run_cmd(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                           input int sda_mode, input bit noise);
        logic [2:0] a;
        logic       s;
        s = (sda_mode == SDA_RAND) ? 1'($urandom) : (sda_mode == SDA_ONE);
        send_req(act, tx, ack, s);
        while (sb.op != OP_IDLE) begin
            a = (noise && $urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : OP_IDLE;
            s = (sda_mode == SDA_RAND) ? 1'($urandom) : (sda_mode == SDA_ONE);
            send_req(a, 8'($urandom), 1'($urandom), s);
        end
    endtask

    initial begin
        t_in_item   step;
        logic [2:0] act;
        logic [7:0] tx;
        logic       ack;
        int         phase_start;
        int         nbytes;

        sb          = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_action    = OP_IDLE;
        i_tx_byte   = '0;
        i_send_ack  = 1'b0;
        i_sda_in    = 1'b1;
        i_out_ready = 1'b0;
        ready_hold  = 0;
        items_sent  = 0;
        cycle_count = 0;
        send_idle   = 1'b1;
        stall_on    = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // Idle ticks and unused action codes at the reset delay: lines stay released.
        send_req(OP_IDLE, 8'h00, 1'b0, 1'b0);
        for (int a = OP_READ + 1; a < 8; a++) begin
            send_req(3'(a), 8'hFF, 1'b1, 1'b1);
        end
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // Zero delay behaves as one tick per unit.
        settle();
        write_delay(8'd0);
        // all-ones byte acked, all-zeros byte nacked with commands thrown in mid byte
        run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b1, SDA_ONE, 1'b1);
        // reads of all ones with ack, all zeros with nack
        run_cmd(OP_READ, 8'h00, 1'b1, SDA_ONE, 1'b0);
        run_cmd(OP_READ, 8'hFF, 1'b0, SDA_LOW, 1'b1);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        send_req(OP_IDLE, 8'h00, 1'b0, 1'b0);

        // Two ticks per unit, a short random transaction.
        settle();
        write_delay(8'd2);
        run_cmd(OP_START, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, 1'b1);
        run_cmd(OP_READ, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), SDA_RAND, 1'b0);

        // Longest unit, no idling on either side to keep it quick.
        settle();
        send_idle = 1'b0;
        stall_on  <= 1'b0;
        write_delay(8'd255);
        // Start a byte and run its first segment well past the shorter unit set
        // below: that segment must close on the very next tick.
        send_req(OP_WRITE, 8'h3C, 1'b0, 1'($urandom));
        repeat (20) send_req(OP_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        settle();
        write_delay(8'd3);
        while (sb.op != OP_IDLE) begin
            send_req(OP_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
        end
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

        // ---- random ----
        // Mostly complete transactions (start, 1..3 bytes, stop) with random data and
        // random SDA; the rest are idle ticks, stray commands, unused codes and commands while busy.
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            send_idle = (ph != 2);
            stall_on  <= (ph != 2);
            write_delay((ph == 2) ? 8'd4 : 8'($urandom_range(0, 3)));
            phase_start = items_sent;
            while (items_sent - phase_start < 50) begin
                tx  = 8'($urandom);
                ack = 1'($urandom);
                if (sb.op == OP_IDLE && $urandom_range(0, 9) != 0) begin
                    if (txn_plan.size() == 0) begin
                        nbytes = $urandom_range(1, 3);
                        step.action   = OP_START;
                        step.tx_byte  = 8'($urandom);
                        step.send_ack = 1'($urandom);
                        step.sda_in   = 1'b0;
                        txn_plan.push_back(step);
                        repeat (nbytes) begin
                            step.action   = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                            step.tx_byte  = 8'($urandom);
                            step.send_ack = 1'($urandom);
                            txn_plan.push_back(step);
                        end
                        step.action = OP_STOP;
                        txn_plan.push_back(step);
                    end
                    step = txn_plan.pop_front();
                    act  = step.action;
                    tx   = step.tx_byte;
                    ack  = step.send_ack;
                end else if (sb.op == OP_IDLE || $urandom_range(0, 7) == 0) begin
                    act = 3'($urandom_range(0, 7));
                end else begin
                    act = OP_IDLE;
                end
                send_req(act, tx, ack, 1'($urandom));
            end
        end

        // ---- wind down ----
        settle();
        repeat (12) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.expected_levels.size() == 0) begin
            $display("i2c_master_byte_sequencer: match");
        end else begin
            $display("i2c_master_byte_sequencer: mismatch");
        end
        $finish;
    end

endmodule
